[design/epp_pkg.sv]
// shared constants, types and tables for the euler pose projection core
package epp_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_W      = 16;
  localparam int SCALE_W      = 16;
  localparam int CORDIC_W     = 20;
  localparam int COEF_W       = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int ANG_CNT_W    = 2;
  localparam int MUL_CNT_W    = 3;
  localparam int NUM_ANGLES   = 3;
  localparam int NUM_PRODS    = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = (COORD_WIDTH > SCALE_W) ? COORD_WIDTH : SCALE_W;
  localparam int IN_DATA_W    = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((2 * COORD_WIDTH + 7) / 8) * 8;

  localparam int PROD_W    = COEF_W + COORD_WIDTH;
  localparam int DOT_W     = PROD_W + 2;
  localparam int SCL_W     = DOT_W + SCALE_W + 1;
  localparam int RND_SHIFT = 28;
  localparam int RND_W     = SCL_W - RND_SHIFT;
  localparam int SUM_W     = RND_W + 1;
  localparam int Q16_SHIFT = 16;

  localparam logic signed [CORDIC_W-1:0] PI_Q16      = CORDIC_W'(205887);
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q16 = CORDIC_W'(102944);
  localparam logic signed [CORDIC_W-1:0] GAIN_Q16    = CORDIC_W'(39797);

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_YAW      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = CFG_IDX_W'(5);

  typedef struct packed {
    logic                     busy;
    logic signed [COEF_W-1:0] r00;
    logic signed [COEF_W-1:0] r01;
    logic signed [COEF_W-1:0] r02;
    logic signed [COEF_W-1:0] r10;
    logic signed [COEF_W-1:0] r11;
    logic signed [COEF_W-1:0] r12;
  } coef_t;

  function automatic logic signed [CORDIC_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [CORDIC_W-1:0] v;
    case (i)
      4'd0:    v = CORDIC_W'(51472);
      4'd1:    v = CORDIC_W'(30385);
      4'd2:    v = CORDIC_W'(16055);
      4'd3:    v = CORDIC_W'(8150);
      4'd4:    v = CORDIC_W'(4091);
      4'd5:    v = CORDIC_W'(2047);
      4'd6:    v = CORDIC_W'(1024);
      4'd7:    v = CORDIC_W'(512);
      4'd8:    v = CORDIC_W'(256);
      4'd9:    v = CORDIC_W'(128);
      4'd10:   v = CORDIC_W'(64);
      4'd11:   v = CORDIC_W'(32);
      4'd12:   v = CORDIC_W'(16);
      4'd13:   v = CORDIC_W'(8);
      4'd14:   v = CORDIC_W'(4);
      4'd15:   v = CORDIC_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/epp_coef.sv]
// rotation coefficient unit: shared cordic for sin/cos and sequential q16 products
module epp_coef import epp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [2:0][ANGLE_W-1:0] angles,
  output coef_t                   coef
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_ROT  = 4'b0100,
    S_MUL  = 4'b1000
  } state_t;

  state_t state;
  logic [ANG_CNT_W-1:0] ang;
  logic [STEP_W-1:0] step;
  logic [MUL_CNT_W-1:0] midx;
  logic flip;
  logic signed [CORDIC_W-1:0] x, y, z;
  logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
  logic signed [CORDIC_W-1:0] sn [NUM_ANGLES];
  logic signed [CORDIC_W-1:0] cs [NUM_ANGLES];
  logic signed [COEF_W-1:0] p [NUM_PRODS];
  logic signed [CORDIC_W-1:0] z_load;
  logic signed [CORDIC_W-1:0] z_red;
  logic flip_load;
  logic signed [COEF_W-1:0] mul_a, mul_b;
  logic signed [2*COEF_W-1:0] prod;
  logic sum_pending;
  logic signed [COEF_W-1:0] r00, r01, r02, r10, r11, r12;

  // angle reduction into +-pi/2
  always_comb begin
    z_load = CORDIC_W'(signed'(angles[ang])) <<< 3;
    z_red = z_load;
    flip_load = 1'b0;
    if (z_load > HALF_PI_Q16) begin
      z_red = z_load - PI_Q16;
      flip_load = 1'b1;
    end else if (z_load < -HALF_PI_Q16) begin
      z_red = z_load + PI_Q16;
      flip_load = 1'b1;
    end
  end

  always_comb begin
    if (!z[CORDIC_W-1]) begin
      x_next = x - (y >>> step);
      y_next = y + (x >>> step);
      z_next = z - atan_q16(step);
    end else begin
      x_next = x + (y >>> step);
      y_next = y - (x >>> step);
      z_next = z + atan_q16(step);
    end
  end

  // operand order: sa*sb, cb*cc, cb*sc, ca*sc, sasb*cc, ca*cc, sasb*sc, sa*cb
  always_comb begin
    case (midx)
      3'd0:    begin mul_a = sn[0]; mul_b = sn[1]; end
      3'd1:    begin mul_a = cs[1]; mul_b = cs[2]; end
      3'd2:    begin mul_a = cs[1]; mul_b = sn[2]; end
      3'd3:    begin mul_a = cs[0]; mul_b = sn[2]; end
      3'd4:    begin mul_a = p[0];  mul_b = cs[2]; end
      3'd5:    begin mul_a = cs[0]; mul_b = cs[2]; end
      3'd6:    begin mul_a = p[0];  mul_b = sn[2]; end
      3'd7:    begin mul_a = sn[0]; mul_b = cs[1]; end
      default: begin mul_a = '0;    mul_b = '0;    end
    endcase
    prod = mul_a * mul_b + (2*COEF_W)'(32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      ang <= '0;
      sum_pending <= 1'b0;
    end else if (start) begin
      state <= S_LOAD;
      ang <= '0;
      sum_pending <= 1'b0;
    end else begin
      sum_pending <= 1'b0;
      case (state)
        S_IDLE: begin
          state <= S_IDLE;
        end
        S_LOAD: begin
          x <= GAIN_Q16;
          y <= '0;
          z <= z_red;
          flip <= flip_load;
          step <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          x <= x_next;
          y <= y_next;
          z <= z_next;
          step <= step + 1'b1;
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            cs[ang] <= flip ? -x_next : x_next;
            sn[ang] <= flip ? -y_next : y_next;
            if (ang == ANG_CNT_W'(NUM_ANGLES - 1)) begin
              midx <= '0;
              state <= S_MUL;
            end else begin
              ang <= ang + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_MUL: begin
          p[midx] <= prod[Q16_SHIFT +: COEF_W];
          midx <= midx + 1'b1;
          if (midx == MUL_CNT_W'(NUM_PRODS - 1)) begin
            sum_pending <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sum_pending) begin
      r00 <= p[1];
      r01 <= -p[2];
      r02 <= COEF_W'(sn[1]);
      r10 <= p[3] + p[4];
      r11 <= p[5] - p[6];
      r12 <= -p[7];
    end
  end

  assign coef = {(state != S_IDLE) || sum_pending, r00, r01, r02, r10, r11, r12};

endmodule

[design/epp_datapath.sv]
// four-stage projection pipeline: products, dot sums, scaling, round/offset/saturate
module epp_datapath import epp_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_WIDTH-1:0]  px,
  input  logic signed [COORD_WIDTH-1:0]  py,
  input  logic signed [COORD_WIDTH-1:0]  pz,
  input  coef_t                          coef,
  input  logic [SCALE_W-1:0]             scale,
  input  logic signed [COORD_WIDTH-1:0]  off_x,
  input  logic signed [COORD_WIDTH-1:0]  off_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [COORD_WIDTH-1:0]  img_x,
  output logic signed [COORD_WIDTH-1:0]  img_y
);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
  localparam logic signed [SCL_W-1:0] RND_HALF = SCL_W'(64'sd1 <<< (RND_SHIFT - 1));

  logic v1, v2, v3;
  logic en1, en2, en3, en4;
  logic signed [PROD_W-1:0] m00, m01, m02, m10, m11, m12;
  logic signed [DOT_W-1:0] dot0, dot1;
  logic signed [SCL_W-1:0] sc0, sc1;
  logic signed [RND_W-1:0] rs0, rs1;
  logic signed [SUM_W-1:0] sum0, sum1;

  assign en4 = !out_valid || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      m00 <= coef.r00 * px;
      m01 <= coef.r01 * py;
      m02 <= coef.r02 * pz;
      m10 <= coef.r10 * px;
      m11 <= coef.r11 * py;
      m12 <= coef.r12 * pz;
    end
    if (en2 && v1) begin
      dot0 <= DOT_W'(m00) + DOT_W'(m01) + DOT_W'(m02);
      dot1 <= DOT_W'(m10) + DOT_W'(m11) + DOT_W'(m12);
    end
    if (en3 && v2) begin
      sc0 <= dot0 * signed'({1'b0, scale});
      sc1 <= dot1 * signed'({1'b0, scale});
    end
    if (en4 && v3) begin
      img_x <= (sum0 > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
               (sum0 < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(sum0);
      img_y <= (sum1 > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
               (sum1 < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(sum1);
    end
  end

  always_comb begin
    rs0 = RND_W'((sc0 + RND_HALF) >>> RND_SHIFT);
    rs1 = RND_W'((sc1 + RND_HALF) >>> RND_SHIFT);
    sum0 = SUM_W'(rs0) + SUM_W'(off_x);
    sum1 = SUM_W'(rs1) + SUM_W'(off_y);
  end

endmodule

[design/euler_pose_point_projection_core.sv]
// top level of the euler pose weak-perspective point projection core
// Takes one 3D point per cycle and returns its projected image position
// through the four-stage pipeline (products, dot sums, scaling,
// round/offset/saturate); a full rate of one word per cycle holds while the
// output is taken and no config write is offered. After reset and after
// every write of an angle register a single shared cordic recomputes the
// rotation coefficients (a load and the rotation steps for each of three
// angles, eight products, one sum), and no point is accepted during that time.
module euler_pose_point_projection_core import epp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y, point_z
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // image_x, image_y
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SCALE_W-1:0] scale_factor;
  logic [2:0][ANGLE_W-1:0] angles;
  logic signed [COORD_WIDTH-1:0] offset_x, offset_y;
  logic cfg_wr, angle_wr;
  coef_t coef;
  logic dp_ready, in_acc;
  logic signed [COORD_WIDTH-1:0] img_x, img_y;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign angle_wr = cfg_wr && (cfg_index == CFG_PITCH || cfg_index == CFG_YAW ||
                               cfg_index == CFG_ROLL);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_W'(4096);
      angles <= '0;
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_SCALE:    scale_factor <= cfg_data[SCALE_W-1:0];
        CFG_PITCH:    angles[0] <= cfg_data[ANGLE_W-1:0];
        CFG_YAW:      angles[1] <= cfg_data[ANGLE_W-1:0];
        CFG_ROLL:     angles[2] <= cfg_data[ANGLE_W-1:0];
        CFG_OFFSET_X: offset_x <= cfg_data[COORD_WIDTH-1:0];
        CFG_OFFSET_Y: offset_y <= cfg_data[COORD_WIDTH-1:0];
        default:      ;
      endcase
    end
  end

  epp_coef u_coef (
    .clk    (clk),
    .rst    (rst),
    .start  (angle_wr),
    .angles (angles),
    .coef   (coef)
  );

  assign s_tready = dp_ready && !coef.busy && !cfg_valid;
  assign in_acc = s_tvalid && s_tready;

  epp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_acc),
    .in_ready  (dp_ready),
    .px        (s_tdata[COORD_WIDTH-1:0]),
    .py        (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .pz        (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .coef      (coef),
    .scale     (scale_factor),
    .off_x     (offset_x),
    .off_y     (offset_y),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .img_x     (img_x),
    .img_y     (img_y)
  );

  assign m_tdata = OUT_DATA_W'({img_y, img_x});

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !coef.busy) else $error("word accepted while coefficients update");
  a_angle_restart: assert property (@(posedge clk) disable iff (rst)
    angle_wr |=> coef.busy) else $error("angle write did not restart coefficients");
  a_reset_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> coef.busy) else $error("no coefficient update after reset");
`endif

endmodule
